>>> hw/rtl/ecb_pkg.sv
// Shared types and codes for the ElGamal byte cipher.
`timescale 1ns / 1ps
package ecb_pkg;

    localparam int SCAN_BITS = 32;
    localparam int CNT_BITS  = 5;

    localparam logic [1:0] REG_MODULUS    = 2'd0;
    localparam logic [1:0] REG_GENERATOR  = 2'd1;
    localparam logic [1:0] REG_PRIVATE    = 2'd2;
    localparam logic [1:0] REG_KEYS_VALID = 2'd3;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam logic BS_GEN = 1'b0;
    localparam logic BS_ACC = 1'b1;

    localparam logic [1:0] ES_PRIV = 2'd0;
    localparam logic [1:0] ES_EPH  = 2'd1;
    localparam logic [1:0] ES_PM2  = 2'd2;

    localparam logic [2:0] SC_ACC  = 3'd0;
    localparam logic [2:0] SC_BASE = 3'd1;
    localparam logic [2:0] SC_C1   = 3'd2;
    localparam logic [2:0] SC_C2   = 3'd3;
    localparam logic [2:0] SC_MSG  = 3'd4;

    localparam logic [1:0] AD_BASE = 2'd0;
    localparam logic [1:0] AD_ONE  = 2'd1;
    localparam logic [1:0] AD_ACC  = 2'd2;
    localparam logic [1:0] AD_HOLD = 2'd3;

    localparam logic DST_ACC  = 1'b0;
    localparam logic DST_BASE = 1'b1;

    typedef struct packed {
        logic       in_ready;
        logic       set_base;
        logic       base_sel;
        logic       set_exp;
        logic [1:0] exp_sel;
        logic       acc_one;
        logic       exp_shift;
        logic       mul_go;
        logic [2:0] scan_sel;
        logic [1:0] add_sel;
        logic       dst;
        logic       save_hold;
        logic       save_first;
        logic       out_load;
        logic       out_err;
    } dp_cmd_t;

    typedef struct packed {
        logic in_fire;
        logic op;
        logic keys_ok;
        logic k_ok;
        logic exp_zero;
        logic exp_lsb;
        logic mul_busy;
        logic mul_done;
        logic out_free;
    } dp_stat_t;

endpackage

>>> hw/rtl/ecb_if.sv
// Input and output beat channels of the ElGamal byte cipher.
`timescale 1ns / 1ps
interface ecb_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [7:0]  message_byte;
    logic [31:0] ephemeral_key;
    logic [31:0] cipher_first;
    logic [31:0] cipher_second;
    logic        last;

    modport source (output valid, operation, message_byte, ephemeral_key, cipher_first,
                    cipher_second, last, input ready);
    modport sink (input valid, operation, message_byte, ephemeral_key, cipher_first,
                  cipher_second, last, output ready);
endinterface

interface ecb_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pair_first;
    logic [31:0] pair_second;
    logic [7:0]  plain_byte;
    logic        status;
    logic        end_of_run;

    modport source (output valid, pair_first, pair_second, plain_byte, status, end_of_run,
                    input ready);
    modport sink (input valid, pair_first, pair_second, plain_byte, status, end_of_run,
                  output ready);
endinterface

>>> hw/rtl/ecb_dp.sv
// Datapath: operand registers, bit-serial modular multiplier, result register.
`timescale 1ns / 1ps
module ecb_dp #(
    parameter int MOD_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [31:0]      modulus,
    input  logic [31:0]      generator,
    input  logic [31:0]      private_key,
    input  logic             keys_valid,
    ecb_in_if.sink           in_ch,
    ecb_out_if.source        out_ch,
    input  ecb_pkg::dp_cmd_t cmd,
    output ecb_pkg::dp_stat_t stat
);
    import ecb_pkg::*;

    localparam int W = MOD_BITS;

    logic                 op_reg, last_reg;
    logic [7:0]           msg_reg;
    logic [31:0]          eph_reg, c1_reg, c2_reg;
    logic [W-1:0]         base_reg, exp_reg, acc_reg, hold_reg, first_reg;
    logic [SCAN_BITS-1:0] mm_scan_reg;
    logic [W-1:0]         mm_add_reg, mm_r_reg;
    logic [CNT_BITS-1:0]  mm_cnt_reg;
    logic                 mm_run_reg, mm_dst_reg;
    logic                 out_valid_reg;
    logic [31:0]          out_pf_reg, out_ps_reg;
    logic [7:0]           out_pb_reg;
    logic                 out_st_reg, out_eor_reg;

    logic [W-1:0]         p_w, mm_r_next, add_mux, exp_mux;
    logic [SCAN_BITS-1:0] scan_mux;
    logic [W:0]           dbl, dbl_red, sum;
    logic                 mm_last, in_fire, blank_pair, blank_byte;

    assign p_w     = modulus[W-1:0];
    assign in_fire = in_ch.valid && in_ch.ready;
    assign mm_last = mm_run_reg && (mm_cnt_reg == '1);

    // one step of MSB-first shift-add reduction
    always_comb
    begin
        dbl     = {mm_r_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, p_w}) ? dbl - {1'b0, p_w} : dbl;
        sum     = {1'b0, dbl_red[W-1:0]} + (mm_scan_reg[SCAN_BITS-1] ? {1'b0, mm_add_reg} : '0);
        mm_r_next = (sum >= {1'b0, p_w}) ? W'(sum - {1'b0, p_w}) : sum[W-1:0];
    end

    always_comb
    begin
        case (cmd.scan_sel)
            SC_ACC:  scan_mux = SCAN_BITS'(acc_reg);
            SC_BASE: scan_mux = SCAN_BITS'(base_reg);
            SC_C1:   scan_mux = c1_reg;
            SC_C2:   scan_mux = c2_reg;
            SC_MSG:  scan_mux = SCAN_BITS'(msg_reg);
            default: scan_mux = '0;
        endcase
        case (cmd.add_sel)
            AD_BASE: add_mux = base_reg;
            AD_ONE:  add_mux = W'(1);
            AD_ACC:  add_mux = acc_reg;
            AD_HOLD: add_mux = hold_reg;
            default: add_mux = '0;
        endcase
        case (cmd.exp_sel)
            ES_PRIV: exp_mux = private_key[W-1:0];
            ES_EPH:  exp_mux = eph_reg[W-1:0];
            ES_PM2:  exp_mux = W'(modulus - 32'd2);
            default: exp_mux = '0;
        endcase
    end

    always_comb
    begin
        stat.in_fire  = in_fire;
        stat.op       = op_reg;
        stat.keys_ok  = keys_valid && (modulus >= 32'd3) && ((modulus >> MOD_BITS) == '0)
                        && (generator >= 32'd2) && (generator <= modulus - 32'd1)
                        && (private_key >= 32'd1) && (private_key <= modulus - 32'd2);
        stat.k_ok     = (eph_reg >= 32'd1) && (eph_reg <= modulus - 32'd2);
        stat.exp_zero = (exp_reg == '0);
        stat.exp_lsb  = exp_reg[0];
        stat.mul_busy = mm_run_reg;
        stat.mul_done = mm_last;
        stat.out_free = !out_valid_reg || out_ch.ready;
    end

    assign in_ch.ready = cmd.in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mm_run_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mm_last)
                mm_run_reg <= 1'b0;
            if (cmd.mul_go)
                mm_run_reg <= 1'b1;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign blank_pair = cmd.out_err || (op_reg == OP_DECRYPT);
    assign blank_byte = cmd.out_err || (op_reg == OP_ENCRYPT);

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg   <= in_ch.operation;
            last_reg <= in_ch.last;
            msg_reg  <= in_ch.message_byte;
            eph_reg  <= in_ch.ephemeral_key;
            c1_reg   <= in_ch.cipher_first;
            c2_reg   <= in_ch.cipher_second;
        end
        if (cmd.set_base)
            base_reg <= (cmd.base_sel == BS_GEN) ? generator[W-1:0] : acc_reg;
        if (cmd.set_exp)
            exp_reg <= exp_mux;
        else if (cmd.exp_shift)
            exp_reg <= exp_reg >> 1;
        if (cmd.acc_one)
            acc_reg <= W'(1);
        if (cmd.save_hold)
            hold_reg <= acc_reg;
        if (cmd.save_first)
            first_reg <= acc_reg;
        if (mm_run_reg)
        begin
            mm_r_reg    <= mm_r_next;
            mm_scan_reg <= mm_scan_reg << 1;
            mm_cnt_reg  <= mm_cnt_reg + 1'b1;
        end
        if (mm_last)
        begin
            if (mm_dst_reg == DST_BASE)
                base_reg <= mm_r_next;
            else
                acc_reg <= mm_r_next;
        end
        if (cmd.mul_go)
        begin
            mm_scan_reg <= scan_mux;
            mm_add_reg  <= add_mux;
            mm_r_reg    <= '0;
            mm_cnt_reg  <= '0;
            mm_dst_reg  <= cmd.dst;
        end
        if (cmd.out_load)
        begin
            out_pf_reg  <= blank_pair ? 32'd0 : 32'(first_reg);
            out_ps_reg  <= blank_pair ? 32'd0 : 32'(acc_reg);
            out_pb_reg  <= blank_byte ? 8'd0 : acc_reg[7:0];
            out_st_reg  <= cmd.out_err;
            out_eor_reg <= last_reg;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.pair_first  = out_pf_reg;
    assign out_ch.pair_second = out_ps_reg;
    assign out_ch.plain_byte  = out_pb_reg;
    assign out_ch.status      = out_st_reg;
    assign out_ch.end_of_run  = out_eor_reg;

endmodule

>>> hw/rtl/ecb_ctrl.sv
// Controller: sequences exponentiations and multiplies for one item.
`timescale 1ns / 1ps
module ecb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  ecb_pkg::dp_stat_t stat,
    output ecb_pkg::dp_cmd_t  cmd
);
    import ecb_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_RED     = 4'd2;
    localparam logic [3:0] S_PW_TEST = 4'd3;
    localparam logic [3:0] S_PW_MUL  = 4'd4;
    localparam logic [3:0] S_PW_SQR  = 4'd5;
    localparam logic [3:0] S_PW_END  = 4'd6;
    localparam logic [3:0] S_FIN     = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    localparam logic [2:0] PH_PUB    = 3'd0;
    localparam logic [2:0] PH_YK     = 3'd1;
    localparam logic [2:0] PH_C1     = 3'd2;
    localparam logic [2:0] PH_SHARED = 3'd3;
    localparam logic [2:0] PH_INV    = 3'd4;

    logic [3:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic       err_reg, err_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        err_next   = err_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_fire)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!stat.keys_ok || (stat.op == OP_ENCRYPT && !stat.k_ok))
                begin
                    err_next   = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.op == OP_ENCRYPT)
                begin
                    err_next     = 1'b0;
                    cmd.set_base = 1'b1;
                    cmd.base_sel = BS_GEN;
                    cmd.set_exp  = 1'b1;
                    cmd.exp_sel  = ES_PRIV;
                    cmd.acc_one  = 1'b1;
                    phase_next   = PH_PUB;
                    state_next   = S_PW_TEST;
                end
                else
                begin
                    err_next     = 1'b0;
                    cmd.mul_go   = 1'b1;
                    cmd.scan_sel = SC_C1;
                    cmd.add_sel  = AD_ONE;
                    cmd.dst      = DST_BASE;
                    state_next   = S_RED;
                end
            end
            S_RED:
            begin
                if (stat.mul_done)
                begin
                    cmd.set_exp = 1'b1;
                    cmd.exp_sel = ES_PRIV;
                    cmd.acc_one = 1'b1;
                    phase_next  = PH_SHARED;
                    state_next  = S_PW_TEST;
                end
            end
            S_PW_TEST:
            begin
                cmd.scan_sel = stat.exp_lsb ? SC_ACC : SC_BASE;
                cmd.add_sel  = AD_BASE;
                if (stat.exp_zero)
                    state_next = S_PW_END;
                else if (stat.exp_lsb)
                begin
                    cmd.mul_go = 1'b1;
                    cmd.dst    = DST_ACC;
                    state_next = S_PW_MUL;
                end
                else
                begin
                    cmd.mul_go    = 1'b1;
                    cmd.dst       = DST_BASE;
                    cmd.exp_shift = 1'b1;
                    state_next    = S_PW_SQR;
                end
            end
            S_PW_MUL:
            begin
                cmd.scan_sel = SC_BASE;
                cmd.add_sel  = AD_BASE;
                cmd.dst      = DST_BASE;
                if (stat.mul_done)
                begin
                    cmd.mul_go    = 1'b1;
                    cmd.exp_shift = 1'b1;
                    state_next    = S_PW_SQR;
                end
            end
            S_PW_SQR:
            begin
                if (stat.mul_done)
                    state_next = S_PW_TEST;
            end
            S_PW_END:
            begin
                case (phase_reg)
                    PH_PUB:
                    begin
                        cmd.set_base = 1'b1;
                        cmd.base_sel = BS_ACC;
                        cmd.set_exp  = 1'b1;
                        cmd.exp_sel  = ES_EPH;
                        cmd.acc_one  = 1'b1;
                        phase_next   = PH_YK;
                        state_next   = S_PW_TEST;
                    end
                    PH_YK:
                    begin
                        cmd.save_hold = 1'b1;
                        cmd.set_base  = 1'b1;
                        cmd.base_sel  = BS_GEN;
                        cmd.set_exp   = 1'b1;
                        cmd.exp_sel   = ES_EPH;
                        cmd.acc_one   = 1'b1;
                        phase_next    = PH_C1;
                        state_next    = S_PW_TEST;
                    end
                    PH_C1:
                    begin
                        cmd.save_first = 1'b1;
                        cmd.mul_go     = 1'b1;
                        cmd.scan_sel   = SC_MSG;
                        cmd.add_sel    = AD_HOLD;
                        cmd.dst        = DST_ACC;
                        state_next     = S_FIN;
                    end
                    PH_SHARED:
                    begin
                        cmd.set_base = 1'b1;
                        cmd.base_sel = BS_ACC;
                        cmd.set_exp  = 1'b1;
                        cmd.exp_sel  = ES_PM2;
                        cmd.acc_one  = 1'b1;
                        phase_next   = PH_INV;
                        state_next   = S_PW_TEST;
                    end
                    PH_INV:
                    begin
                        cmd.mul_go   = 1'b1;
                        cmd.scan_sel = SC_C2;
                        cmd.add_sel  = AD_ACC;
                        cmd.dst      = DST_ACC;
                        state_next   = S_FIN;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_FIN:
            begin
                if (stat.mul_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.out_err = err_reg;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_PUB;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            err_reg   <= err_next;
        end
    end

    a_accept_checks: assert property (@(posedge clk) disable iff (!rst_n)
        stat.in_fire |=> state_reg == S_CHECK)
        else $error("accepted beat did not start a check");

    a_mul_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_go |-> (!stat.mul_busy || stat.mul_done))
        else $error("multiply started while unit busy");

    a_done_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && stat.out_free) |=> state_reg == S_IDLE)
        else $error("result not handed off");

endmodule

>>> hw/rtl/elgamal_byte_cipher.sv
// Top level of the ElGamal byte cipher: register port, controller and datapath.
// Usage:
//   Software writes modulus, generator and private_key over the APB port, then
//   sets keys_valid once it has checked that p is prime and g a generator.
//   Each input beat carries either a byte and ephemeral key to encrypt or a
//   cipher pair to decrypt; each gives exactly one output beat, with status 1
//   and zero data when the keys or the ephemeral key are out of range.
// Work:
//   One bit-serial modular multiplier does all the work. An exponentiation
//   with a MOD_BITS-bit exponent takes up to 2*MOD_BITS products. Encrypt runs
//   three exponentiations and one product; decrypt runs two exponentiations and
//   two products. Error results pass from the check state through the done
//   state to the output register after the input beat is accepted. One item is
//   in work at a time.
// Reset and stall:
//   rst_n zeroes the key registers and the run and valid flags, and idles the
//   controller. A result waits in the output register while the receiver
//   stalls; meanwhile the next item is taken, worked on and held till it frees.
`timescale 1ns / 1ps
module elgamal_byte_cipher #(
    parameter int MOD_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ecb_in_if.sink      in_ch,
    ecb_out_if.source   out_ch
);
    import ecb_pkg::*;

    logic [31:0] modulus_reg, generator_reg, private_key_reg;
    logic        keys_valid_reg;
    logic        wr_en;
    dp_cmd_t     cmd;
    dp_stat_t    stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg     <= '0;
            generator_reg   <= '0;
            private_key_reg <= '0;
            keys_valid_reg  <= 1'b0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_MODULUS:    modulus_reg     <= pwdata;
                REG_GENERATOR:  generator_reg   <= pwdata;
                REG_PRIVATE:    private_key_reg <= pwdata;
                REG_KEYS_VALID: keys_valid_reg  <= pwdata[0];
                default:        keys_valid_reg  <= keys_valid_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MODULUS:    prdata = modulus_reg;
            REG_GENERATOR:  prdata = generator_reg;
            REG_PRIVATE:    prdata = private_key_reg;
            REG_KEYS_VALID: prdata = {31'd0, keys_valid_reg};
            default:        prdata = '0;
        endcase
    end

    ecb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    ecb_dp #(
        .MOD_BITS (MOD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .modulus     (modulus_reg),
        .generator   (generator_reg),
        .private_key (private_key_reg),
        .keys_valid  (keys_valid_reg),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

>>> bench/ecb_tb_chk.sv
// Checker for the ElGamal byte cipher: predicts each result and compares it beat by beat.
`timescale 1ns / 1ps
module ecb_tb_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    ecb_in_if           in_ch,
    ecb_out_if          out_ch,
    output int          fail_count,
    output int          pending
);
    import ecb_pkg::*;

    typedef struct packed {
        logic [31:0] pair_first;
        logic [31:0] pair_second;
        logic [7:0]  plain_byte;
        logic        status;
        logic        end_of_run;
    } cipher_res_t;

    logic [31:0] p_mod, g_gen, x_priv, y_pub;
    logic        kv;
    cipher_res_t expected_q[$];

    function automatic logic [31:0] mod_pow(logic [31:0] b, logic [31:0] e, logic [31:0] m);
        logic [63:0] acc, bb;
        logic [31:0] ee;
        if (m == 0) return '0;
        bb = b % m;
        acc = 1 % m;
        ee = e;
        while (ee != 0)
        begin
            if (ee[0]) acc = (acc * bb) % m;
            ee = ee >> 1;
            bb = (bb * bb) % m;
        end
        return acc[31:0];
    endfunction

    function automatic bit keys_ok();
        if (kv != 1'b1) return 0;
        if (p_mod < 3) return 0;
        if (g_gen < 2 || g_gen > p_mod - 1) return 0;
        if (x_priv < 1 || x_priv > p_mod - 2) return 0;
        return 1;
    endfunction

    function automatic cipher_res_t predict_cipher(logic op, logic [7:0] m, logic [31:0] k,
                                                   logic [31:0] c1, logic [31:0] c2,
                                                   logic lst);
        cipher_res_t r;
        logic [63:0] t;
        logic [31:0] sh, inv;
        r = '0;
        r.end_of_run = lst;
        if (!keys_ok()) r.status = 1;
        else if (op == OP_ENCRYPT)
        begin
            if (k < 1 || k > p_mod - 2) r.status = 1;
            else
            begin
                r.pair_first = mod_pow(g_gen, k, p_mod);
                t = (64'(m) * mod_pow(y_pub, k, p_mod)) % p_mod;
                r.pair_second = t[31:0];
            end
        end
        else
        begin
            sh = mod_pow(c1, x_priv, p_mod);
            inv = mod_pow(sh, p_mod - 2, p_mod);
            t = (64'(c2) * inv) % p_mod;
            r.plain_byte = t[7:0];
        end
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        cipher_res_t got, exp_r;
        if (!rst_n)
        begin
            p_mod = 0; g_gen = 0; x_priv = 0; kv = 0; y_pub = 0;
            fail_count <= 0;
            expected_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_MODULUS:    p_mod = pwdata;
                    REG_GENERATOR:  g_gen = pwdata;
                    REG_PRIVATE:    x_priv = pwdata;
                    REG_KEYS_VALID: kv = pwdata[0];
                    default:        kv = kv;
                endcase
                y_pub = keys_ok() ? mod_pow(g_gen, x_priv, p_mod) : '0;
            end
            if (in_ch.valid && in_ch.ready)
                expected_q.push_back(predict_cipher(in_ch.operation, in_ch.message_byte,
                    in_ch.ephemeral_key, in_ch.cipher_first, in_ch.cipher_second,
                    in_ch.last));
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.pair_first, out_ch.pair_second, out_ch.plain_byte,
                        out_ch.status, out_ch.end_of_run};
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (got != exp_r)
                    begin
                        $display("%0t: mismatch, expected c1=%h c2=%h m=%h st=%b eor=%b",
                                 $time, exp_r.pair_first, exp_r.pair_second,
                                 exp_r.plain_byte, exp_r.status, exp_r.end_of_run);
                        $display("%0t:           actual c1=%h c2=%h m=%h st=%b eor=%b",
                                 $time, got.pair_first, got.pair_second, got.plain_byte,
                                 got.status, got.end_of_run);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> bench/tb_top.sv
// Top of the ElGamal byte cipher bench: stimulus, register setup and verdict.
`timescale 1ns / 1ps
module tb_top;
    import ecb_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending;
    int          idle_cycles = 0;
    bit          long_hold = 0;

    ecb_in_if  in_ch();
    ecb_out_if out_ch();

    elgamal_byte_cipher uut (.clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_ch(in_ch), .out_ch(out_ch));

    ecb_tb_chk chk (.clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .pready(pready), .paddr(paddr), .pwdata(pwdata), .in_ch(in_ch),
        .out_ch(out_ch), .fail_count(fail_count), .pending(pending));

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    initial
    begin
        in_ch.valid = 0; in_ch.operation = 0; in_ch.message_byte = 0;
        in_ch.ephemeral_key = 0; in_ch.cipher_first = 0; in_ch.cipher_second = 0;
        in_ch.last = 0; out_ch.ready = 0;
    end

    // watchdog: cycles with no beat on either channel and no register access
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 60000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver with random stalls and one long hold-off
    always @(posedge clk)
    begin
        int w;
        if (rst_n)
        begin
            if (long_hold)
            begin
                out_ch.ready <= 0;
                repeat (20000) @(posedge clk);
                long_hold = 0;
            end
            else if (out_ch.ready && out_ch.valid || !out_ch.ready)
            begin
                w = $urandom_range(0, 16);
                if ($urandom_range(0, 3) == 0) w = 0;
                if (w == 0) out_ch.ready <= 1;
                else
                begin
                    out_ch.ready <= 0;
                    repeat (w) @(posedge clk);
                    out_ch.ready <= 1;
                end
            end
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic set_keys(logic [31:0] p, logic [31:0] g, logic [31:0] x, logic v);
        in_ch.valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (7000) @(posedge clk);
        reg_write(REG_MODULUS, p);
        reg_write(REG_GENERATOR, g);
        reg_write(REG_PRIVATE, x);
        reg_write(REG_KEYS_VALID, {31'b0, v});
    endtask

    task automatic send_beat(logic op, logic [7:0] m, logic [31:0] k, logic [31:0] c1,
                             logic [31:0] c2, logic lst, bit no_gap);
        int w;
        w = no_gap ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0) w = 0;
        if (w > 0)
        begin
            in_ch.valid <= 0;
            repeat (w) @(posedge clk);
        end
        in_ch.valid <= 1; in_ch.operation <= op; in_ch.message_byte <= m;
        in_ch.ephemeral_key <= k; in_ch.cipher_first <= c1; in_ch.cipher_second <= c2;
        in_ch.last <= lst;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic random_beats(int n, logic [31:0] p);
        int i;
        logic [31:0] k;
        for (i = 0; i < n; i++)
        begin
            k = ($urandom_range(0, 7) == 0) ? $urandom : (p > 3 ? $urandom_range(1, p - 2) : 1);
            send_beat(1'($urandom_range(0, 1)), 8'($urandom), k,
                      ($urandom_range(0, 1) ? $urandom : $urandom % p), $urandom,
                      1'($urandom), 0);
        end
    endtask

    initial
    begin
        int i;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        // no keys set yet: every item errors
        send_beat(OP_ENCRYPT, 8'h00, 32'd1, 0, 0, 1, 0);
        send_beat(OP_DECRYPT, 8'hff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0);

        set_keys(32'd4294967291, 32'd2, 32'd123456789, 1);
        send_beat(OP_ENCRYPT, 8'h00, 32'd1, 0, 0, 0, 0);
        send_beat(OP_ENCRYPT, 8'hff, 32'd4294967289, 0, 0, 1, 0);
        send_beat(OP_ENCRYPT, 8'h5a, 32'd0, 0, 0, 0, 0);
        send_beat(OP_ENCRYPT, 8'h5a, 32'd4294967290, 0, 0, 0, 0);
        send_beat(OP_ENCRYPT, 8'h5a, 32'hffffffff, 0, 0, 0, 0);
        send_beat(OP_DECRYPT, 8'h00, 0, 32'd0, 32'd77, 0, 0);
        send_beat(OP_DECRYPT, 8'h00, 0, 32'd4294967291, 32'd77, 0, 0);
        send_beat(OP_DECRYPT, 8'h00, 0, 32'hffffffff, 32'hffffffff, 1, 0);
        send_beat(OP_DECRYPT, 8'h00, 0, 32'd1, 32'd0, 0, 0);

        // back-pressure: receiver holds off while the sender keeps offering
        long_hold = 1;
        for (i = 0; i < 4; i++) send_beat(i[0], 8'($urandom), $urandom_range(1, 1000),
                                          $urandom, $urandom, 0, 1);
        random_beats(40, 32'd4294967291);

        // smallest prime, then invalid key settings
        set_keys(32'd3, 32'd2, 32'd1, 1);
        random_beats(15, 32'd3);
        set_keys(32'd3, 32'd3, 32'd1, 1);
        send_beat(OP_ENCRYPT, 8'h11, 32'd1, 0, 0, 0, 0);
        set_keys(32'd65521, 32'd17, 32'd0, 1);
        send_beat(OP_ENCRYPT, 8'h11, 32'd1, 0, 0, 0, 0);
        set_keys(32'd65521, 32'd17, 32'd65520, 1);
        send_beat(OP_DECRYPT, 8'h11, 0, 32'd5, 32'd9, 0, 0);
        set_keys(32'd65521, 32'd17, 32'd65519, 0);
        send_beat(OP_ENCRYPT, 8'h11, 32'd1, 0, 0, 0, 0);
        set_keys(32'd2, 32'd1, 32'd1, 1);
        send_beat(OP_ENCRYPT, 8'h11, 32'd1, 0, 0, 0, 0);

        set_keys(32'd65521, 32'd65520, 32'd65519, 1);
        random_beats(35, 32'd65521);
        set_keys(32'd251, 32'd6, 32'd200, 1);
        random_beats(35, 32'd251);

        in_ch.valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (7000) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/ecb_pkg.sv
hw/rtl/ecb_if.sv
hw/rtl/ecb_dp.sv
hw/rtl/ecb_ctrl.sv
hw/rtl/elgamal_byte_cipher.sv
bench/ecb_tb_chk.sv
bench/tb_top.sv
